>>> src/elfd_pkg.sv
`default_nettype none
package elfd_pkg;

  // Raw framing bytes seen on the wire.
  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EscByte   = 8'hA5;

  // Parser modes of the receive side.
  typedef enum logic [2:0] {
    ModeDiscard,
    ModeId,
    ModeLength,
    ModePayload,
    ModeChecksum
  } mode_e;

  // The emitting side hands a payload bank back to the parser.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage
`default_nettype wire

>>> src/elfd_front.sv
`default_nettype none
module elfd_front
  import elfd_pkg::*;
#(
  parameter int unsigned MaxPayload = 32,
  parameter int unsigned LenW       = 6,
  parameter int unsigned AddrW      = 5
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          byte_in_i,
  input  wire bank_rel_t           rel_i,
  output logic                     wr_en_o,
  output logic [AddrW:0]           wr_addr_o,
  output logic [7:0]               wr_data_o,
  output logic                     push_o,
  output logic [8+LenW:0]          push_data_o
);

  mode_e             mode_q, mode_d;
  logic              esc_q, esc_d;
  logic [7:0]        id_q, id_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   pos_inc;
  logic              wbank_q, wbank_d;
  logic [1:0]        busy_q, busy_d;

  logic              accept;
  logic              is_start;
  logic              esc_hit;
  logic              deliver;
  logic [7:0]        ub;

  // The payload bank being filled may still be drained by the back end.
  assign in_ready_o = !(busy_q[wbank_q] &&
                        (mode_q == ModePayload || mode_q == ModeChecksum));

  assign accept   = in_valid_i && in_ready_o;
  assign is_start = (byte_in_i == StartByte);
  assign esc_hit  = !esc_q && (byte_in_i == EscByte);
  assign ub       = esc_q ? (byte_in_i ^ EscByte) : byte_in_i;
  assign deliver  = accept && !is_start && !esc_hit;
  assign esc_d    = accept ? (!is_start && esc_hit) : esc_q;
  assign pos_inc  = pos_q + 1'b1;

  // Next mode.
  always_comb begin
    mode_d = mode_q;
    if (accept && is_start) begin
      mode_d = ModeId;
    end else if (deliver) begin
      case (mode_q)
        ModeId: begin
          mode_d = ModeLength;
        end
        ModeLength: begin
          if (32'(ub) > 32'(MaxPayload)) begin
            mode_d = ModeDiscard;
          end else if (ub == 8'h00) begin
            mode_d = ModeChecksum;
          end else begin
            mode_d = ModePayload;
          end
        end
        ModePayload: begin
          if (pos_inc >= len_q) begin
            mode_d = ModeChecksum;
          end
        end
        ModeChecksum: begin
          mode_d = ModeDiscard;
        end
        default: begin
          mode_d = ModeDiscard;
        end
      endcase
    end
  end

  // Buffer writes, frame fields and descriptor hand-off.
  always_comb begin
    id_d        = id_q;
    len_d       = len_q;
    pos_d       = pos_q;
    wbank_d     = wbank_q;
    busy_d      = busy_q;
    wr_en_o     = 1'b0;
    push_o      = 1'b0;
    wr_addr_o   = {wbank_q, pos_q[AddrW-1:0]};
    wr_data_o   = ub;
    push_data_o = {id_q, len_q, wbank_q};
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (deliver) begin
      case (mode_q)
        ModeId: begin
          id_d = ub;
        end
        ModeLength: begin
          if (32'(ub) <= 32'(MaxPayload)) begin
            len_d = ub[LenW-1:0];
            pos_d = '0;
          end
        end
        ModePayload: begin
          wr_en_o = 1'b1;
          pos_d   = pos_inc;
        end
        ModeChecksum: begin
          push_o          = 1'b1;
          busy_d[wbank_q] = 1'b1;
          wbank_d         = !wbank_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeDiscard;
      esc_q   <= 1'b0;
      id_q    <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      wbank_q <= 1'b0;
      busy_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      id_q    <= id_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      wbank_q <= wbank_d;
      busy_q  <= busy_d;
    end
  end

endmodule
`default_nettype wire

>>> src/elfd_queue.sv
`default_nettype none
module elfd_queue #(
  parameter int unsigned DataW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] push_data_i,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [DataW-1:0]      pop_data_o
);

  logic [DataW-1:0] entry_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_pop;

  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/elfd_back.sv
`default_nettype none
module elfd_back
  import elfd_pkg::*;
#(
  parameter int unsigned LenW       = 6,
  parameter int unsigned AddrW      = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             desc_valid_i,
  input  wire logic [8+LenW:0]  desc_data_i,
  output logic                  desc_pop_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW:0]   wr_addr_i,
  input  wire logic [7:0]       wr_data_i,
  output bank_rel_t             rel_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [7:0]            frame_id_o,
  output logic [5:0]            frame_length_o,
  output logic                  has_data_o,
  output logic [4:0]            data_index_o,
  output logic [7:0]            data_byte_o,
  output logic                  last_o
);

  localparam int unsigned MemDepth = 2 ** (AddrW + 1);

  logic [7:0]      mem_q [MemDepth];
  logic [7:0]      rd_data_q;

  logic            active_q;
  logic [7:0]      cur_id_q;
  logic [LenW-1:0] cur_len_q;
  logic            cur_bank_q;
  logic [LenW-1:0] cnt_q;
  logic [LenW-1:0] cnt_inc;

  logic            s1_q;
  logic [7:0]      s1_id_q;
  logic [LenW-1:0] s1_len_q;
  logic            s1_has_q;
  logic [LenW-1:0] s1_idx_q;
  logic            s1_last_q;

  logic            out_valid_q;
  logic [7:0]      out_id_q;
  logic [5:0]      out_len_q;
  logic            out_has_q;
  logic [4:0]      out_idx_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;

  logic            issue;
  logic            is_last;
  logic [AddrW:0]  rd_addr;
  logic [31:0]     len_ext;
  logic [31:0]     idx_ext;

  assign desc_pop_o = desc_valid_i && !active_q;
  assign cnt_inc    = cnt_q + 1'b1;
  assign is_last    = (cur_len_q == '0) || (cnt_inc == cur_len_q);
  assign issue      = active_q && !s1_q && (!out_valid_q || out_ready_i);
  assign rd_addr    = {cur_bank_q, cnt_q[AddrW-1:0]};
  assign len_ext    = 32'(s1_len_q);
  assign idx_ext    = 32'(s1_idx_q);

  always_comb begin
    rel_o.valid = issue && is_last;
    rel_o.bank  = cur_bank_q;
  end

  // Payload buffer: two banks, one written by the parser, one read here.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Current descriptor registers, and payload registers of the read stage and the output stage.
  always_ff @(posedge clk_i) begin
    if (desc_pop_o) begin
      cur_id_q   <= desc_data_i[8+LenW:1+LenW];
      cur_len_q  <= desc_data_i[LenW:1];
      cur_bank_q <= desc_data_i[0];
    end
    if (issue) begin
      s1_id_q   <= cur_id_q;
      s1_len_q  <= cur_len_q;
      s1_has_q  <= (cur_len_q != '0);
      s1_idx_q  <= cnt_q;
      s1_last_q <= is_last;
    end
    if (s1_q) begin
      out_id_q   <= s1_id_q;
      out_len_q  <= len_ext[5:0];
      out_has_q  <= s1_has_q;
      out_idx_q  <= idx_ext[4:0];
      out_byte_q <= s1_has_q ? rd_data_q : 8'h00;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cnt_q       <= '0;
      s1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (desc_pop_o) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (issue) begin
        if (is_last) begin
          active_q <= 1'b0;
        end else begin
          cnt_q <= cnt_inc;
        end
      end
      s1_q <= issue;
      if (s1_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_id_o     = out_id_q;
  assign frame_length_o = out_len_q;
  assign has_data_o     = out_has_q;
  assign data_index_o   = out_idx_q;
  assign data_byte_o    = out_byte_q;
  assign last_o         = out_last_q;

endmodule
`default_nettype wire

>>> src/escaped_length_frame_decoder.sv
// The first result of a frame follows its checksum byte through the descriptor queue,
// the back end's payload read register and its output register. Throughput: one input byte
// per cycle while ready; a new payload read waits until the previous one has left the read register.
// Input stalls only while the next payload bank is still being drained by the output side.
// Reset: control state is cleared at once; the payload buffer holds no reset value.
`default_nettype none
module escaped_length_frame_decoder
  import elfd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      frame_id_o,
  output logic [5:0]      frame_length_o,
  output logic            has_data_o,
  output logic [4:0]      data_index_o,
  output logic [7:0]      data_byte_o,
  output logic            last_o
);

  // Length counter must hold MAX_PAYLOAD itself; the buffer index only its entries.
  localparam int unsigned LenW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned DescW = 9 + LenW;

  bank_rel_t        rel;
  logic             wr_en;
  logic [AddrW:0]   wr_addr;
  logic [7:0]       wr_data;
  logic             push;
  logic [DescW-1:0] push_data;
  logic             desc_valid;
  logic [DescW-1:0] desc_data;
  logic             desc_pop;

  // The front end strips escapes, tracks the frame layout and fills one of two
  // payload banks. On the checksum byte it queues a descriptor (id, length, bank).
  elfd_front #(
    .MaxPayload (MAX_PAYLOAD),
    .LenW       (LenW),
    .AddrW      (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .rel_i       (rel),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Two descriptors at most can be outstanding, one per payload bank.
  elfd_queue #(
    .DataW (DescW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .valid_o     (desc_valid),
    .pop_i       (desc_pop),
    .pop_data_o  (desc_data)
  );

  // The back end walks a completed frame's bank and emits one result transfer per payload
  // byte, or one transfer without data for an empty frame, then releases the bank to the front end.
  elfd_back #(
    .LenW       (LenW),
    .AddrW      (AddrW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_valid_i   (desc_valid),
    .desc_data_i    (desc_data),
    .desc_pop_o     (desc_pop),
    .wr_en_i        (wr_en),
    .wr_addr_i      (wr_addr),
    .wr_data_i      (wr_data),
    .rel_o          (rel),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_id_o     (frame_id_o),
    .frame_length_o (frame_length_o),
    .has_data_o     (has_data_o),
    .data_index_o   (data_index_o),
    .data_byte_o    (data_byte_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
